FILE: sv/desk_height_frame_decoder_defines.svh
// Assertion macros used by the desk height frame decoder top level.
`ifndef DESK_HEIGHT_FRAME_DECODER_DEFINES_SVH
`define DESK_HEIGHT_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define DHFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define DHFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/dhfd_pkg.sv
// Types, constants and helper functions of the desk height frame decoder.
package dhfd_pkg;

  // Frame buffer geometry
  localparam int FrameBytes = 7;
  localparam int IdxW       = $clog2(FrameBytes);
  localparam int HeightW    = 14;

  // Special bytes on the link
  localparam logic [7:0] ByteIdle  = 8'h00;
  localparam logic [7:0] ByteStart = 8'h9B;
  localparam logic [7:0] ByteEnd   = 8'h9D;
  localparam logic [7:0] FrameId0  = 8'h07;
  localparam logic [7:0] FrameId1  = 8'h12;

  // Digit code for an unknown segment pattern
  localparam logic [3:0] DigitBad = 4'd10;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STANDING  = 2'd0,
    REG_SITTING   = 2'd1,
    REG_TOLERANCE = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    POSTURE_UNKNOWN  = 2'd0,
    POSTURE_STANDING = 2'd1,
    POSTURE_SITTING  = 2'd2
  } posture_e;

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  typedef struct packed {
    logic [HeightW-1:0] standing;
    logic [HeightW-1:0] sitting;
    logic [HeightW-1:0] tolerance;
  } cfg_t;

  // Result of parsing the frame buffer at an end marker
  typedef struct packed {
    logic [HeightW-1:0] height;
    logic               height_frame;
    logic               sign_off;
    logic               digit_error;
  } parse_t;

  // Seven-segment pattern to digit, bit 7 ignored
  function automatic logic [3:0] seg_digit(logic [7:0] b);
    logic [3:0] d;
    unique case (b[6:0])
      7'h3F:   d = 4'd0;
      7'h06:   d = 4'd1;
      7'h5B:   d = 4'd2;
      7'h4F:   d = 4'd3;
      7'h66:   d = 4'd4;
      7'h6D:   d = 4'd5;
      7'h7D:   d = 4'd6;
      7'h07:   d = 4'd7;
      7'h7F:   d = 4'd8;
      7'h6F:   d = 4'd9;
      default: d = DigitBad;
    endcase
    return d;
  endfunction

  function automatic logic [HeightW-1:0] abs_diff(logic [HeightW-1:0] a,
                                                  logic [HeightW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: sv/dhfd_if.sv
// Stream interfaces of the desk height frame decoder: bytes, results, config.

interface dhfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dhfd_res_if;
  logic        valid;
  logic        ready;
  logic [13:0] height_now;
  logic [1:0]  posture;
  logic        frame_end;
  logic        height_frame;
  logic        sign_off;
  logic        digit_error;

  modport source (output valid, output height_now, output posture, output frame_end,
                  output height_frame, output sign_off, output digit_error,
                  input ready);
  modport sink   (input valid, input height_now, input posture, input frame_end,
                  input height_frame, input sign_off, input digit_error,
                  output ready);
endinterface

interface dhfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [13:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/dhfd_frame_buf.sv
// Frame byte buffer with clamped write index.
module dhfd_frame_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            write_i,
  input  logic [7:0]      byte_i,
  output dhfd_pkg::frame_t frame_o
);
  import dhfd_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(FrameBytes - 1);

  frame_t          frame_q;
  logic [IdxW-1:0] wr_idx_q;

  // Clear on start marker, otherwise store and advance until the last slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      wr_idx_q <= '0;
    end else if (clear_i) begin
      frame_q  <= '0;
      wr_idx_q <= '0;
    end else if (write_i) begin
      frame_q[wr_idx_q] <= byte_i;
      if (wr_idx_q != LastIdx) begin
        wr_idx_q <= wr_idx_q + 1'b1;
      end
    end
  end

  assign frame_o = frame_q;

endmodule

FILE: sv/dhfd_parse.sv
// Height frame parser: header check, segment decode and height scaling.
module dhfd_parse (
  input  dhfd_pkg::frame_t frame_i,
  output dhfd_pkg::parse_t parse_o
);
  import dhfd_pkg::*;

  logic               is_height_type;
  logic               all_set;
  logic [3:0]         d2, d3, d4;
  logic               digits_ok;
  logic [HeightW-1:0] h_fine;
  logic [HeightW-1:0] h_coarse;

  assign is_height_type = (frame_i[0] == FrameId0) && (frame_i[1] == FrameId1);
  assign all_set = (frame_i[4] != 8'h00) && (frame_i[5] != 8'h00) && (frame_i[6] != 8'h00);

  assign d2 = seg_digit(frame_i[2]);
  assign d3 = seg_digit(frame_i[3]);
  assign d4 = seg_digit(frame_i[4]);
  assign digits_ok = (d2 < DigitBad) && (d3 < DigitBad) && (d4 < DigitBad);

  // Decimal point on byte 3 selects tenths resolution
  assign h_fine   = HeightW'(d2) * HeightW'(100) + HeightW'(d3) * HeightW'(10)
                  + HeightW'(d4);
  assign h_coarse = HeightW'(d2) * HeightW'(1000) + HeightW'(d3) * HeightW'(100)
                  + HeightW'(d4) * HeightW'(10);

  always_comb begin
    parse_o              = '0;
    parse_o.height       = frame_i[3][7] ? h_fine : h_coarse;
    parse_o.height_frame = is_height_type && all_set && digits_ok;
    parse_o.digit_error  = is_height_type && all_set && !digits_ok;
    parse_o.sign_off     = is_height_type && !all_set;
  end

endmodule

FILE: sv/dhfd_posture.sv
// Posture classifier: compares a height against the two targets.
module dhfd_posture (
  input  logic [dhfd_pkg::HeightW-1:0] height_i,
  input  dhfd_pkg::posture_e           posture_i,
  input  dhfd_pkg::cfg_t               cfg_i,
  output dhfd_pkg::posture_e           posture_o
);
  import dhfd_pkg::*;

  logic near_stand;
  logic near_sit;

  assign near_stand = abs_diff(height_i, cfg_i.standing) <= cfg_i.tolerance;
  assign near_sit   = abs_diff(height_i, cfg_i.sitting) <= cfg_i.tolerance;

  // Standing wins; no known height, or none near a target, keeps the old posture
  always_comb begin
    posture_o = posture_i;
    if (height_i != '0) begin
      if (near_stand) begin
        posture_o = POSTURE_STANDING;
      end else if (near_sit) begin
        posture_o = POSTURE_SITTING;
      end
    end
  end

endmodule

FILE: sv/desk_height_frame_decoder.sv
// Desk height frame decoder top level: byte register, decode, result register.
// A byte accepted into the byte register moves on to the result register when
// that one is empty or being read. Throughput: one byte per cycle unless the
// result side stalls; frame buffer, height and posture update as it moves on.
// Reset: rst_ni clears frame buffer, write index, height, posture, config
// registers and both valid flags at once.
module desk_height_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhfd_rx_if.sink     rx_i,
  dhfd_res_if.source  res_o,
  dhfd_cfg_if.sink    cfg_i
);
  import dhfd_pkg::*;

  `include "desk_height_frame_decoder_defines.svh"

  // Configuration registers
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_STANDING:  cfg_q.standing  <= cfg_i.data;
        REG_SITTING:   cfg_q.sitting   <= cfg_i.data;
        REG_TOLERANCE: cfg_q.tolerance <= cfg_i.data;
        default:       ;
      endcase
    end
  end

  // Input byte register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Byte classes
  logic is_start, is_end, is_data;

  assign is_start = (in_byte_q == ByteStart);
  assign is_end   = (in_byte_q == ByteEnd);
  assign is_data  = (in_byte_q != ByteIdle) && !is_start && !is_end;

  frame_t frame;
  parse_t parse;

  dhfd_frame_buf u_frame_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (advance && is_start),
    .write_i (advance && is_data),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  dhfd_parse u_parse (
    .frame_i (frame),
    .parse_o (parse)
  );

  // Held height and posture
  logic [HeightW-1:0] height_q, height_d;
  posture_e           posture_q, posture_d;

  assign height_d = (is_end && parse.height_frame && (parse.height != '0)) ?
                    parse.height : height_q;

  dhfd_posture u_posture (
    .height_i  (height_d),
    .posture_i (posture_q),
    .cfg_i     (cfg_q),
    .posture_o (posture_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q  <= '0;
      posture_q <= POSTURE_UNKNOWN;
    end else if (advance) begin
      height_q  <= height_d;
      posture_q <= posture_d;
    end
  end

  // Result register
  logic res_end_q, res_height_q, res_sign_q, res_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_end_q    <= is_end;
      res_height_q <= is_end && parse.height_frame;
      res_sign_q   <= is_end && parse.sign_off;
      res_err_q    <= is_end && parse.digit_error;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.height_now   = height_q;
  assign res_o.posture      = posture_q;
  assign res_o.frame_end    = res_end_q;
  assign res_o.height_frame = res_height_q;
  assign res_o.sign_off     = res_sign_q;
  assign res_o.digit_error  = res_err_q;

  // Checks
  `DHFD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q,
                    "result word lost after advance")
  `DHFD_ASSERT_NOW(a_flags_need_end, out_valid_q && !res_end_q,
                   !(res_height_q || res_sign_q || res_err_q),
                   "frame flag raised without end marker")
  `DHFD_ASSERT_NOW(a_flags_exclusive, out_valid_q,
                   $onehot0({res_height_q, res_sign_q, res_err_q}),
                   "more than one frame flag raised")
  `DHFD_ASSERT_NEXT(a_stalled_height_holds, out_valid_q && !res_o.ready,
                    $stable(height_q),
                    "held height changed while result stalled")

endmodule

FILE: verif/desk_height_frame_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the desk height frame decoder: watches all channels, predicts and compares.
module desk_height_frame_decoder_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhfd_rx_if         rx_i,
  dhfd_res_if        res_i,
  dhfd_cfg_if        cfg_i,
  output int         fail_count_o,
  output int         pending_o
);
  import dhfd_pkg::*;

  // One result word as the decoder should present it
  typedef struct packed {
    logic [HeightW-1:0] height;
    posture_e           posture;
    logic               frame_end;
    logic               height_frame;
    logic               sign_off;
    logic               digit_error;
  } desk_word_t;

  // Segment patterns of digits 0 to 9, bit 7 not included
  localparam logic [6:0] SegPattern [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                             7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
  localparam int NotDigit = 10;

  logic [7:0]         frame_q [FrameBytes];
  int unsigned        wr_slot;
  logic [HeightW-1:0] held_height;
  posture_e           held_posture;
  cfg_t               targets;
  desk_word_t         words_due [$];
  int                 mismatches;

  // Digit value of a segment byte, NotDigit when the pattern is unknown
  function automatic int seg_value(logic [7:0] b);
    int v;
    v = NotDigit;
    for (int i = 0; i < 10; i++) begin
      if (b[6:0] == SegPattern[i]) v = i;
    end
    return v;
  endfunction

  // Apply one link byte to the frame state and build the word it causes
  function automatic desk_word_t take_link_byte(logic [7:0] b);
    desk_word_t         w;
    int                 d2, d3, d4;
    int unsigned        h;
    logic [HeightW-1:0] to_stand, to_sit;
    w = '0;
    if (b == ByteStart) begin
      for (int i = 0; i < FrameBytes; i++) frame_q[i] = '0;
      wr_slot = 0;
    end else if (b == ByteEnd) begin
      w.frame_end = 1'b1;
      if (frame_q[0] == FrameId0 && frame_q[1] == FrameId1) begin
        if (frame_q[4] != 8'd0 && frame_q[5] != 8'd0 && frame_q[6] != 8'd0) begin
          d2 = seg_value(frame_q[2]);
          d3 = seg_value(frame_q[3]);
          d4 = seg_value(frame_q[4]);
          if (d2 < NotDigit && d3 < NotDigit && d4 < NotDigit) begin
            // top bit of the middle digit picks the fine scale
            if (frame_q[3][7]) h = d2 * 100 + d3 * 10 + d4;
            else               h = d2 * 1000 + d3 * 100 + d4 * 10;
            w.height_frame = 1'b1;
            if (h != 0) held_height = h[HeightW-1:0];
          end else begin
            w.digit_error = 1'b1;
          end
        end else begin
          w.sign_off = 1'b1;
        end
      end
    end else if (b != ByteIdle) begin
      // write slot saturates on the last entry
      frame_q[wr_slot] = b;
      if (wr_slot < FrameBytes - 1) wr_slot++;
    end

    // posture follows a nonzero height, standing first
    if (held_height != '0) begin
      to_stand = (held_height > targets.standing) ? held_height - targets.standing
                                                  : targets.standing - held_height;
      to_sit   = (held_height > targets.sitting) ? held_height - targets.sitting
                                                 : targets.sitting - held_height;
      if (to_stand <= targets.tolerance)   held_posture = POSTURE_STANDING;
      else if (to_sit <= targets.tolerance) held_posture = POSTURE_SITTING;
    end
    w.height  = held_height;
    w.posture = held_posture;
    return w;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Track config writes and bytes, compare every result word
  always @(posedge clk_i or negedge rst_ni) begin
    desk_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < FrameBytes; i++) frame_q[i] = '0;
      wr_slot      = 0;
      held_height  = '0;
      held_posture = POSTURE_UNKNOWN;
      targets      = '0;
      words_due.delete();
      mismatches   = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_STANDING:  targets.standing  = cfg_i.data;
          REG_SITTING:   targets.sitting   = cfg_i.data;
          REG_TOLERANCE: targets.tolerance = cfg_i.data;
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) words_due.push_back(take_link_byte(rx_i.rx_byte));
      if (res_i.valid && res_i.ready) begin
        if (words_due.size() == 0) begin
          report_mismatch("result word with none expected");
        end else begin
          want = words_due.pop_front();
          if (res_i.height_now !== want.height)
            report_mismatch($sformatf("height_now %0d, want %0d", res_i.height_now,
                                      want.height));
          if (res_i.posture !== want.posture)
            report_mismatch($sformatf("posture %0d, want %0d", res_i.posture,
                                      want.posture));
          if (res_i.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, want %b", res_i.frame_end,
                                      want.frame_end));
          if (res_i.height_frame !== want.height_frame)
            report_mismatch($sformatf("height_frame %b, want %b", res_i.height_frame,
                                      want.height_frame));
          if (res_i.sign_off !== want.sign_off)
            report_mismatch($sformatf("sign_off %b, want %b", res_i.sign_off,
                                      want.sign_off));
          if (res_i.digit_error !== want.digit_error)
            report_mismatch($sformatf("digit_error %b, want %b", res_i.digit_error,
                                      want.digit_error));
        end
      end
    end
    fail_count_o = mismatches;
    pending_o    = words_due.size();
  end

endmodule

FILE: verif/desk_height_frame_decoder_tb.sv
`timescale 1ns / 1ps
// Testbench top of the desk height frame decoder: clock, reset, byte and config stimulus, verdict.
module desk_height_frame_decoder_tb;
  import dhfd_pkg::*;

  localparam int ByteTarget   = 1350;
  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 4;
  localparam logic [1:0] RegSpare = 2'd3;
  localparam logic [6:0] SegPattern [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                             7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

  logic clk_i = 1'b0;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   bytes_sent;
  bit   no_gaps;
  int   cfg_stand, cfg_sit, cfg_tol;
  logic [7:0] link_seq [$];

  dhfd_rx_if  rx_if ();
  dhfd_res_if res_if ();
  dhfd_cfg_if cfg_if ();

  desk_height_frame_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  desk_height_frame_decoder_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_if),
    .res_i        (res_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length: mostly none, some short, a few long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  initial begin
    int hold;
    int stall;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      res_if.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = pick_pause();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  function automatic logic [7:0] seg_byte(int d, bit top);
    return {top, SegPattern[d]};
  endfunction

  // Any byte that gets stored in the frame buffer
  function automatic logic [7:0] any_payload();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == ByteStart || b == ByteEnd);
    return b;
  endfunction

  function automatic int near_target(int c);
    int spread, h;
    spread = (cfg_tol > 100) ? 100 : cfg_tol;
    h = c + int'($urandom_range(0, 2 * spread + 4)) - (spread + 2);
    if (h < 0) h = 0;
    if (h > 9999) h = 9999;
    return h;
  endfunction

  function automatic int pick_height();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 4) return near_target(cfg_stand);
    if (r < 7) return near_target(cfg_sit);
    return $urandom_range(0, 9999);
  endfunction

  task automatic put_byte(logic [7:0] b);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    if (b != ByteIdle) bytes_sent++;
  endtask

  task automatic send_seq();
    foreach (link_seq[i]) put_byte(link_seq[i]);
    link_seq.delete();
  endtask

  // Stop sending and wait until every word has come back
  task automatic quiesce();
    rx_if.valid <= 1'b0;
    @(posedge clk_i);
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic load_config(int st, int si, int tol, bit spare);
    if (spare) write_reg(RegSpare, 14'($urandom_range(0, 16383)));
    write_reg(REG_STANDING, 14'(st));
    write_reg(REG_SITTING, 14'(si));
    write_reg(REG_TOLERANCE, 14'(tol));
    cfg_if.valid <= 1'b0;
    cfg_stand = st;
    cfg_sit   = si;
    cfg_tol   = tol;
  endtask

  // Height frame: optional start byte, id, three digits, two filler bytes,
  // optional extra bytes past the end of the buffer, end marker
  task automatic queue_height_frame(int h, bit lead, int extra);
    int d2, d3, d4, first;
    bit fine;
    first = link_seq.size();
    if (lead) link_seq.push_back(ByteStart);
    link_seq.push_back(FrameId0);
    link_seq.push_back(FrameId1);
    fine = (h < 1000) && ($urandom_range(0, 1) == 1);
    if (fine) begin
      d2 = h / 100;
      d3 = (h / 10) % 10;
      d4 = h % 10;
    end else begin
      d2 = h / 1000;
      d3 = (h / 100) % 10;
      d4 = (h / 10) % 10;
    end
    link_seq.push_back(seg_byte(d2, 1'($urandom_range(0, 1))));
    link_seq.push_back(seg_byte(d3, fine));
    link_seq.push_back(seg_byte(d4, 1'($urandom_range(0, 1))));
    repeat (2 + extra) link_seq.push_back(any_payload());
    if ($urandom_range(0, 7) == 0)
      link_seq.insert($urandom_range(first, link_seq.size()), ByteIdle);
    link_seq.push_back(ByteEnd);
  endtask

  // One random sequence: mostly good frames, the rest broken ones and noise
  task automatic random_sequence();
    int kind, bad;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
    if (kind < 60) begin
      queue_height_frame(pick_height(), $urandom_range(0, 19) != 0, 0);
    end else if (kind < 68) begin
      // short frame leaves a zero among the last three bytes
      link_seq.push_back(ByteStart);
      link_seq.push_back(FrameId0);
      link_seq.push_back(FrameId1);
      repeat ($urandom_range(0, 4)) link_seq.push_back(any_payload());
      link_seq.push_back(ByteEnd);
    end else if (kind < 76) begin
      // full frame with one digit slot holding a random byte
      bad = $urandom_range(0, 2);
      link_seq.push_back(ByteStart);
      link_seq.push_back(FrameId0);
      link_seq.push_back(FrameId1);
      for (int i = 0; i < 3; i++) begin
        if (i == bad) link_seq.push_back(any_payload());
        else link_seq.push_back(seg_byte($urandom_range(0, 9), 1'($urandom_range(0, 1))));
      end
      repeat (2) link_seq.push_back(any_payload());
      link_seq.push_back(ByteEnd);
    end else if (kind < 82) begin
      // foreign frame id
      link_seq.push_back(ByteStart);
      link_seq.push_back($urandom_range(0, 1) ? FrameId0 : any_payload());
      repeat (6) link_seq.push_back(any_payload());
      link_seq.push_back(ByteEnd);
    end else if (kind < 88) begin
      queue_height_frame(pick_height(), 1'b1, $urandom_range(1, 4));
    end else begin
      repeat ($urandom_range(1, 6)) link_seq.push_back(8'($urandom_range(0, 255)));
    end
    send_seq();
    if ($urandom_range(0, 49) == 0) quiesce();
  endtask

  // Main stimulus and verdict
  initial begin
    int goal;
    rst_ni        <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    no_gaps    = 1'b0;
    bytes_sent = 0;
    cfg_stand  = 0;
    cfg_sit    = 0;
    cfg_tol    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bytes on reset config: idle byte, end on empty buffer,
    // sign-off, fine scale height with buffer overrun, bad digit
    link_seq = '{ByteIdle, ByteEnd,
                 ByteStart, FrameId0, FrameId1, seg_byte(2, 0), seg_byte(3, 1),
                 seg_byte(4, 0), 8'hFF, ByteEnd,
                 8'h08, 8'hFF, ByteEnd,
                 ByteStart, FrameId0, FrameId1, seg_byte(0, 1), 8'h40, seg_byte(9, 1),
                 8'h80, 8'hFE, ByteEnd};
    send_seq();
    quiesce();

    // Random phases, each on its own config
    for (int phase = 0; bytes_sent < ByteTarget; phase++) begin
      case (phase)
        0:       load_config(1100, 720, 20, 1'b0);
        1:       load_config(16383, 16383, 16383, 1'b0);
        2:       load_config(0, 0, 0, 1'b1);
        3:       load_config(0, 9999, 9999, 1'b0);
        4:       load_config(9999, 0, 0, 1'b1);
        default: load_config($urandom_range(500, 1300), $urandom_range(500, 1300),
                             $urandom_range(0, 60), 1'b0);
      endcase
      goal = bytes_sent + ByteTarget / 7;
      while (bytes_sent < goal) random_sequence();
      quiesce();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
